>>> src/deadline_ordered_timer_queue_unit_defines.svh
// Assertion macros shared by the timer queue checker.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DOTQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DOTQ_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/dotq_pkg.sv
// Package with widths, codes and shared types of the timer queue.
package dotq_pkg;

  localparam int TIME_W         = 64;
  localparam int TID_W          = 4;
  localparam int CNT_W          = 5;
  localparam int ID_LIMIT       = 16;
  localparam int NUM_TIMERS_DEF = 16;
  localparam int IN_DATA_W      = 200;
  localparam int OUT_DATA_W     = 16;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] dl;
    logic [TID_W-1:0]  id;
  } rot_t;

  typedef struct packed {
    logic              start;
    logic              stop;
    logic              snap;
    logic              shift;
    logic              emit;
    logic [TID_W-1:0]  id;
    logic [CNT_W-1:0]  query;
    logic [TIME_W-1:0] timeout;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
  } ctrl_t;

endpackage

>>> src/dotq_cell.sv
// One timer slot of the ring: its state, its ranking counter and its ring stage.
module dotq_cell #(
  parameter logic [dotq_pkg::TID_W-1:0] CELL_ID = '0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  dotq_pkg::ctrl_t ctrl,
  input  dotq_pkg::rot_t  rot_in,
  output dotq_pkg::rot_t  rot_out,
  output logic            hit
);

  logic                          armed_r;
  logic                          elig_r;
  logic [dotq_pkg::TIME_W-1:0]   deadline_r;
  logic [dotq_pkg::TIME_W-1:0]   period_r;
  logic [dotq_pkg::CNT_W-1:0]    rank_r;
  dotq_pkg::rot_t                rot_r;
  logic                          sel;
  logic                          due;
  logic                          earlier;
  logic                          fire;
  logic [dotq_pkg::TIME_W-1:0]   addend;
  logic [dotq_pkg::TIME_W:0]     sum;
  logic [dotq_pkg::TIME_W-1:0]   sat;

  assign sel     = (ctrl.id == CELL_ID);
  assign due     = armed_r && (deadline_r <= ctrl.now);
  assign hit     = elig_r && (rank_r == ctrl.query);
  assign fire    = ctrl.emit && hit;
  assign earlier = rot_in.vld &&
                   ((rot_in.dl < deadline_r) ||
                    ((rot_in.dl == deadline_r) && (rot_in.id < CELL_ID)));
  assign addend  = ctrl.start ? ctrl.timeout : period_r;
  assign sum     = {1'b0, ctrl.now} + {1'b0, addend};
  assign sat     = sum[dotq_pkg::TIME_W] ? '1 : sum[dotq_pkg::TIME_W-1:0];
  assign rot_out = rot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      elig_r  <= 1'b0;
    end else begin
      if (ctrl.start && sel) begin
        armed_r <= 1'b1;
      end else if (ctrl.stop && sel) begin
        armed_r <= 1'b0;
      end else if (fire && (period_r == '0)) begin
        armed_r <= 1'b0;
      end
      if (ctrl.snap) begin
        elig_r <= due;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start && sel) begin
      deadline_r <= sat;
      period_r   <= ctrl.period;
    end else if (fire && (period_r != '0)) begin
      deadline_r <= sat;
    end
    if (ctrl.snap) begin
      rank_r <= '0;
      rot_r  <= '{vld: due, dl: deadline_r, id: CELL_ID};
    end else if (ctrl.shift) begin
      rot_r <= rot_in;
      if (earlier) begin
        rank_r <= rank_r + dotq_pkg::CNT_W'(1);
      end
    end
  end

endmodule

>>> src/deadline_ordered_timer_queue_unit.sv
// Top level of the timer queue: beat capture, sequencer and the ring of timer cells.
// A start or stop beat (or any other non-tick beat) is acknowledged from S_CMD once the output register is free.
// A tick snapshots the cells in S_CMD; then, with more than one cell, the ring in S_RANK passes every deadline
// once around so each due cell counts its rank; then S_EMIT gives one result per fired timer
// and a finish beat. The number of cells is NUM_TIMERS, at most 16.
// One input item is in work at a time. Reset clears all armed marks at once.
module deadline_ordered_timer_queue_unit #(
  parameter int NUM_TIMERS = dotq_pkg::NUM_TIMERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // timer_id, timeout, repeat_interval, now, zero pad
  input  logic [dotq_pkg::IN_DATA_W-1:0]   in_tdata,
  // func
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // fired_id, fired_count, zero pad
  output logic [dotq_pkg::OUT_DATA_W-1:0]  out_tdata,
  // kind
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);

  localparam int NumCells = (NUM_TIMERS < dotq_pkg::ID_LIMIT) ? NUM_TIMERS
                                                             : dotq_pkg::ID_LIMIT;
  localparam logic [dotq_pkg::CNT_W-1:0] LastStep = dotq_pkg::CNT_W'(NumCells - 1);
  localparam int PadW = dotq_pkg::OUT_DATA_W - dotq_pkg::TID_W - dotq_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMD  = 4'b0010,
    S_RANK = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                         state_r;
  state_t                         state_nxt;
  logic [dotq_pkg::CNT_W-1:0]     step_r;
  logic [dotq_pkg::CNT_W-1:0]     step_nxt;
  logic [1:0]                     func_r;
  logic [dotq_pkg::TID_W-1:0]     id_r;
  logic [dotq_pkg::TIME_W-1:0]    timeout_r;
  logic [dotq_pkg::TIME_W-1:0]    period_r;
  logic [dotq_pkg::TIME_W-1:0]    now_r;
  logic                           out_valid_r;
  logic [1:0]                     out_kind_r;
  logic [dotq_pkg::TID_W-1:0]     out_id_r;
  logic [dotq_pkg::CNT_W-1:0]     out_cnt_r;
  logic                           out_last_r;
  logic                           out_ld;
  logic                           emit_ack;
  logic                           emit_tick;
  logic                           any_hit;
  logic [dotq_pkg::TID_W-1:0]     hit_id;
  logic [NumCells-1:0]            hit;
  dotq_pkg::rot_t                 rot [NumCells];
  dotq_pkg::ctrl_t                ctrl;

  assign in_tready  = (state_r == S_IDLE);
  assign out_ld     = !out_valid_r || out_tready;
  assign emit_ack   = (state_r == S_CMD) && (func_r != dotq_pkg::FUNC_TICK) && out_ld;
  assign emit_tick  = (state_r == S_EMIT) && out_ld;
  assign any_hit    = |hit;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PadW'(0), out_cnt_r, out_id_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    hit_id = '0;
    for (int i = 0; i < NumCells; i++) begin
      if (hit[i]) begin
        hit_id = hit_id | dotq_pkg::TID_W'(i);
      end
    end
  end

  always_comb begin
    ctrl.start   = emit_ack && (func_r == dotq_pkg::FUNC_START);
    ctrl.stop    = emit_ack && (func_r == dotq_pkg::FUNC_STOP);
    ctrl.snap    = (state_r == S_CMD) && (func_r == dotq_pkg::FUNC_TICK);
    ctrl.shift   = (state_r == S_RANK);
    ctrl.emit    = emit_tick;
    ctrl.id      = id_r;
    ctrl.query   = step_r;
    ctrl.timeout = timeout_r;
    ctrl.period  = period_r;
    ctrl.now     = now_r;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (func_r == dotq_pkg::FUNC_TICK) begin
          if (NumCells > 1) begin
            step_nxt  = dotq_pkg::CNT_W'(1);
            state_nxt = S_RANK;
          end else begin
            step_nxt  = '0;
            state_nxt = S_EMIT;
          end
        end else if (out_ld) begin
          state_nxt = S_IDLE;
        end
      end
      S_RANK: begin
        if (step_r == LastStep) begin
          step_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          step_nxt = step_r + dotq_pkg::CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_ld) begin
          if (any_hit) begin
            step_nxt = step_r + dotq_pkg::CNT_W'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (out_ld) begin
        out_valid_r <= emit_ack || emit_tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r    <= in_tuser;
      id_r      <= in_tdata[dotq_pkg::TID_W-1:0];
      timeout_r <= in_tdata[dotq_pkg::TID_W +: dotq_pkg::TIME_W];
      period_r  <= in_tdata[dotq_pkg::TID_W + dotq_pkg::TIME_W +: dotq_pkg::TIME_W];
      now_r     <= in_tdata[dotq_pkg::TID_W + 2 * dotq_pkg::TIME_W +: dotq_pkg::TIME_W];
    end
    if (emit_ack) begin
      out_kind_r <= dotq_pkg::KIND_ACK;
      out_id_r   <= id_r;
      out_cnt_r  <= '0;
      out_last_r <= 1'b1;
    end else if (emit_tick) begin
      if (any_hit) begin
        out_kind_r <= dotq_pkg::KIND_FIRED;
        out_id_r   <= hit_id;
        out_cnt_r  <= '0;
        out_last_r <= 1'b0;
      end else begin
        out_kind_r <= dotq_pkg::KIND_FINISH;
        out_id_r   <= '0;
        out_cnt_r  <= step_r;
        out_last_r <= 1'b1;
      end
    end
  end

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    dotq_cell #(
      .CELL_ID(dotq_pkg::TID_W'(g))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .rot_in (rot[(g + NumCells - 1) % NumCells]),
      .rot_out(rot[g]),
      .hit    (hit[g])
    );
  end

endmodule

>>> src/dotq_checker.sv
// Port-level checker of the timer queue and its binding to the top level.
`include "deadline_ordered_timer_queue_unit_defines.svh"

module dotq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dotq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser,
  input logic                            out_tlast
);

  `DOTQ_ASSERT_NR(a_rst_idle, clk, !rst_n |=> !out_tvalid && in_tready, "not idle after reset")
  `DOTQ_ASSERT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "beat taken while busy")
  `DOTQ_ASSERT(a_last_kind, clk, rst_n, out_tvalid |-> ((out_tuser == dotq_pkg::KIND_FIRED) != out_tlast), "tlast does not match the result kind")
  `DOTQ_ASSERT(a_count_range, clk, rst_n, out_tvalid && (out_tuser == dotq_pkg::KIND_FINISH) |-> out_tdata[dotq_pkg::TID_W +: dotq_pkg::CNT_W] <= dotq_pkg::CNT_W'(dotq_pkg::ID_LIMIT), "fired count out of range")
  `DOTQ_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result beat changed")

endmodule

bind deadline_ordered_timer_queue_unit dotq_checker u_dotq_checker (.*);

>>> tb/deadline_ordered_timer_queue_unit_tb.sv
// Self-checking testbench for the deadline-ordered timer queue with periodic reload.
`timescale 1ns / 100ps

module deadline_ordered_timer_queue_unit_tb;

  localparam int SLOTS = dotq_pkg::NUM_TIMERS_DEF;
  localparam int TIME_W = dotq_pkg::TIME_W;
  localparam int TID_W = dotq_pkg::TID_W;
  localparam int CNT_W = dotq_pkg::CNT_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int RANDOM_ITEMS = 80;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] T_ALT_A = {(TIME_W/2){2'b10}};
  localparam logic [TIME_W-1:0] T_ALT_5 = {(TIME_W/2){2'b01}};

  typedef struct {
    logic [1:0]       kind;
    logic [TID_W-1:0] id;
    logic [CNT_W-1:0] count;
    logic             last;
  } timer_event_t;

  typedef struct {
    logic [1:0]        fn;
    logic [TID_W-1:0]  id;
    logic [TIME_W-1:0] tmo;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] now;
    bit                typed;
    logic [1:0]        kind;
  } script_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [dotq_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [1:0]                      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [dotq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;
  logic                            out_tlast;

  logic              tq_armed [SLOTS];
  logic [TIME_W-1:0] tq_deadline [SLOTS];
  logic [TIME_W-1:0] tq_period [SLOTS];

  timer_event_t expected_events[$];
  script_row_t  script[$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           quiet = 1'b0;
  logic         squeeze = 1'b0;
  bit           squeeze_done = 1'b0;
  int           squeeze_cnt = 0;

  deadline_ordered_timer_queue_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? T_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  task automatic timer_table_step(input logic [1:0] fn, input logic [TID_W-1:0] id,
                                  input logic [TIME_W-1:0] tmo,
                                  input logic [TIME_W-1:0] per,
                                  input logic [TIME_W-1:0] now, input bit record);
    bit fired [SLOTS];
    int best;
    int n;
    for (int i = 0; i < SLOTS; i++) fired[i] = 1'b0;
    if (fn != dotq_pkg::FUNC_TICK) begin
      if (fn == dotq_pkg::FUNC_START) begin
        tq_deadline[id] = sat_sum(now, tmo);
        tq_period[id] = per;
        tq_armed[id] = 1'b1;
      end else if (fn == dotq_pkg::FUNC_STOP) begin
        tq_armed[id] = 1'b0;
      end
      if (record) expected_events.push_back('{dotq_pkg::KIND_ACK, id, '0, 1'b1});
    end else begin
      n = 0;
      best = 0;
      while (best >= 0) begin
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (tq_armed[i] && !fired[i] && tq_deadline[i] <= now &&
              (best < 0 || tq_deadline[i] < tq_deadline[best])) begin
            best = i;
          end
        end
        if (best >= 0) begin
          fired[best] = 1'b1;
          tq_armed[best] = 1'b0;
          if (tq_period[best] != '0) begin
            tq_deadline[best] = sat_sum(now, tq_period[best]);
            tq_armed[best] = 1'b1;
          end
          if (record) begin
            expected_events.push_back('{dotq_pkg::KIND_FIRED, best[TID_W-1:0], '0, 1'b0});
          end
          n++;
        end
      end
      if (record) begin
        expected_events.push_back('{dotq_pkg::KIND_FINISH, '0, n[CNT_W-1:0], 1'b1});
      end
    end
  endtask

  task automatic drive_item(input logic [1:0] fn, input logic [TID_W-1:0] id,
                            input logic [TIME_W-1:0] tmo, input logic [TIME_W-1:0] per,
                            input logic [TIME_W-1:0] now, input bit typed,
                            input logic [1:0] kind);
    while (!quiet && $urandom_range(0, 99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {{(dotq_pkg::IN_DATA_W - TID_W - 3*TIME_W){1'b0}}, now, per, tmo, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    timer_table_step(fn, id, tmo, per, now, !typed);
    if (typed) begin
      expected_events.push_back('{kind, (kind == dotq_pkg::KIND_ACK) ? id : '0, '0, 1'b1});
    end
  endtask

  task automatic add_row(input logic [1:0] fn, input logic [TID_W-1:0] id,
                         input logic [TIME_W-1:0] tmo, input logic [TIME_W-1:0] per,
                         input logic [TIME_W-1:0] now, input bit typed,
                         input logic [1:0] kind);
    script.push_back('{fn, id, tmo, per, now, typed, kind});
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    timer_event_t ev;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result beat: kind %0d id %0d", out_tuser, out_tdata[TID_W-1:0]);
        error_count++;
      end else begin
        ev = expected_events.pop_front();
        check_field("kind", 64'(ev.kind), 64'(out_tuser));
        check_field("fired_id", 64'(ev.id), 64'(out_tdata[TID_W-1:0]));
        check_field("fired_count", 64'(ev.count), 64'(out_tdata[TID_W +: CNT_W]));
        check_field("last", 64'(ev.last), 64'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (squeeze && !squeeze_done) begin
      if (squeeze_cnt < SQUEEZE_CYCLES) begin
        squeeze_cnt++;
        out_tready <= 1'b0;
      end else begin
        squeeze_done = 1'b1;
        out_tready <= 1'b1;
      end
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** deadline_ordered_timer_queue_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] cur;
    logic [TIME_W-1:0] tmo;
    logic [TIME_W-1:0] per;
    int sel;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= dotq_pkg::FUNC_START;
    for (int i = 0; i < SLOTS; i++) begin
      tq_armed[i] = 1'b0;
      tq_deadline[i] = '0;
      tq_period[i] = '0;
    end

    add_row(dotq_pkg::FUNC_TICK,  4'd0,  '0,      '0,      64'd0,   1'b1,
            dotq_pkg::KIND_FINISH);
    add_row(dotq_pkg::FUNC_STOP,  4'd5,  '0,      '0,      64'd0,   1'b1, dotq_pkg::KIND_ACK);
    add_row(FUNC_NONE,            4'd9,  T_MAX,   T_MAX,   64'd0,   1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_START, 4'd0,  64'd10,  64'd0,   64'd0,   1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_START, 4'd15, T_MAX,   T_MAX,   64'd1,   1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_START, 4'd3,  64'd10,  64'd5,   64'd0,   1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_START, 4'd7,  64'd5,   64'd0,   64'd0,   1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_START, 4'd2,  64'd10,  64'd0,   64'd0,   1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_TICK,  4'd0,  '0,      '0,      64'd4,   1'b1,
            dotq_pkg::KIND_FINISH);
    add_row(dotq_pkg::FUNC_TICK,  4'd0,  '0,      '0,      64'd20,  1'b0,
            dotq_pkg::KIND_FINISH);
    add_row(dotq_pkg::FUNC_TICK,  4'd0,  '0,      '0,      64'd25,  1'b0,
            dotq_pkg::KIND_FINISH);
    add_row(dotq_pkg::FUNC_STOP,  4'd3,  '0,      '0,      64'd25,  1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_START, 4'd8,  64'd5,   64'd0,   64'd30,  1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_START, 4'd8,  64'd100, 64'd0,   64'd30,  1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_TICK,  4'd0,  '0,      '0,      64'd40,  1'b1,
            dotq_pkg::KIND_FINISH);
    add_row(dotq_pkg::FUNC_TICK,  4'd0,  '0,      '0,      T_MAX,   1'b0,
            dotq_pkg::KIND_FINISH);
    add_row(dotq_pkg::FUNC_TICK,  4'd0,  '0,      '0,      T_MAX,   1'b0,
            dotq_pkg::KIND_FINISH);
    add_row(dotq_pkg::FUNC_START, 4'd4,  64'd0,   64'd0,   T_MAX,   1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_STOP,  4'd15, '0,      '0,      T_MAX,   1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_START, 4'd6,  T_ALT_5, T_ALT_A, T_ALT_5, 1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_START, 4'd6,  T_ALT_A, T_ALT_5, T_ALT_A, 1'b1, dotq_pkg::KIND_ACK);
    add_row(dotq_pkg::FUNC_TICK,  4'd0,  '0,      '0,      T_MAX,   1'b0,
            dotq_pkg::KIND_FINISH);
    add_row(dotq_pkg::FUNC_STOP,  4'd6,  '0,      '0,      T_MAX,   1'b1, dotq_pkg::KIND_ACK);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      drive_item(script[r].fn, script[r].id, script[r].tmo, script[r].per, script[r].now,
                 script[r].typed, script[r].kind);
    end

    cur = 64'd1000;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 25) squeeze <= 1'b1;
      quiet = (k >= 45 && k < 65);
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        for (int j = 0; j < SLOTS; j++) begin
          per = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(1, 20)) : '0;
          drive_item(dotq_pkg::FUNC_START, j[TID_W-1:0], 64'($urandom_range(0, 3)), per,
                     cur, 1'b0, dotq_pkg::KIND_ACK);
        end
        cur = cur + 64'd3;
        drive_item(dotq_pkg::FUNC_TICK, TID_W'($urandom_range(0, 15)), '0, '0, cur, 1'b0,
                   dotq_pkg::KIND_FINISH);
      end else if (sel < 50) begin
        sel = $urandom_range(0, 99);
        tmo = (sel < 60) ? 64'($urandom_range(0, 60)) :
              (sel < 80) ? rand_time() :
              (sel < 90) ? T_MAX : T_MAX - 64'($urandom_range(0, 100));
        sel = $urandom_range(0, 99);
        per = (sel < 40) ? '0 : (sel < 85) ? 64'($urandom_range(1, 50)) : rand_time();
        drive_item(dotq_pkg::FUNC_START, TID_W'($urandom_range(0, 15)), tmo, per, cur, 1'b0,
                   dotq_pkg::KIND_ACK);
      end else if (sel < 65) begin
        drive_item(dotq_pkg::FUNC_STOP, TID_W'($urandom_range(0, 15)), rand_time(),
                   rand_time(), cur, 1'b0, dotq_pkg::KIND_ACK);
      end else if (sel < 70) begin
        drive_item(FUNC_NONE, TID_W'($urandom_range(0, 15)), rand_time(), rand_time(), cur,
                   1'b0, dotq_pkg::KIND_ACK);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 3) cur = rand_time();
        else if (sel < 5) cur = T_MAX - 64'($urandom_range(0, 100));
        else cur = cur + 64'($urandom_range(0, 40));
        drive_item(dotq_pkg::FUNC_TICK, TID_W'($urandom_range(0, 15)), rand_time(),
                   rand_time(), cur, 1'b0, dotq_pkg::KIND_FINISH);
      end
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (expected_events.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("** deadline_ordered_timer_queue_unit: PASSED **");
    end else begin
      $display("** deadline_ordered_timer_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/dotq_pkg.sv
src/dotq_cell.sv
src/deadline_ordered_timer_queue_unit.sv
src/dotq_checker.sv
tb/deadline_ordered_timer_queue_unit_tb.sv
